### design/fwt2d_pkg.sv
// Package for the two-dimensional Fenwick tree: payload types and codes.
package fwt2d_pkg;

  localparam int unsigned IdxW   = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned WordW  = 64;

  // Item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [IdxW-1:0]         row_top;
    logic [IdxW-1:0]         col_left;
    logic [IdxW-1:0]         row_bottom;
    logic [IdxW-1:0]         col_right;
    logic signed [WordW-1:0] value;
  } fwt2d_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] rect_sum;
    logic                    status;
  } fwt2d_out_t;

endpackage

### design/fwt2d_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fwt2d_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/fenwick_tree_2d_rect_sum.sv
// Top level of the two-dimensional Fenwick tree with rectangle sums.
//
// Two-dimensional binary indexed tree over a grid of up to MAX_ROWS by MAX_COLS
// 64-bit cells in one RAM with one read and one write port. After reset a
// clearing pass writes zero to every word, during which no item is taken
// (configuration writes still are). One item is worked at a time: an add
// visits each node of its row chain times column chain, one node per cycle
// (read issued, then read-modify-write through the shared 64-bit adder in
// the cycle after), then passes the drain and done states. A query runs
// four prefix walks, one node per cycle, each walk set up in ST_QINIT. The
// walks visit
// (popcount(top) + popcount(bottom+1)) * (popcount(left) + popcount(right+1))
// nodes, so at 64 by 64 that is at most 11*11 nodes, typically far fewer.
// Rejected items go straight from idle to the done state. The RAM read port
// and the single adder set this rate. The result sits in an output register,
// so the next item is taken while it waits.
module fenwick_tree_2d_rect_sum #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [6:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fwt2d_pkg::fwt2d_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fwt2d_pkg::fwt2d_out_t  out_data_o
);

  import fwt2d_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowsRst = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int unsigned ColsRst = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int unsigned WalkW = SizeW + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_QINIT = 3'd3;
  localparam logic [2:0] ST_QWALK = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v, int unsigned maxv);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (32'(v) > maxv) r = SizeW'(maxv);
    return r;
  endfunction

  function automatic logic [WalkW-1:0] lowbit(logic [WalkW-1:0] x);
    return x & (~x + WalkW'(1));
  endfunction

  function automatic logic [AddrW-1:0] node_addr(logic [WalkW-1:0] i, logic [WalkW-1:0] j);
    return AddrW'((32'(i) - 32'd1) * MAX_COLS + (32'(j) - 32'd1));
  endfunction

  logic [2:0]         state_q, state_d;
  logic [SizeW-1:0]   rows_q, cols_q;
  logic [AddrW-1:0]   clr_q, clr_d;
  fwt2d_in_t          item_q, item_d;
  logic               err_q, err_d;
  logic [WalkW-1:0]   i_q, i_d, j_q, j_d, jstart_q, jstart_d;
  logic [1:0]         term_q, term_d;
  logic signed [WordW-1:0] acc_q, acc_d;
  logic               pend_q, pend_d;
  logic               pneg_q, pneg_d;
  logic [AddrW-1:0]   paddr_q, paddr_d;
  logic               out_valid_q, out_valid_d;
  fwt2d_out_t         out_q, out_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [WordW-1:0]   ram_wdata, ram_rdata;

  logic [WordW-1:0]   sum_a, sum_b, sum;
  logic               sum_cin;
  logic [WalkW-1:0]   term_r, term_c, i_next, j_next;
  logic               term_neg;
  logic               in_xfer, out_xfer, bad_item;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  // Check indices against the configured grid and, for queries, their order
  always_comb begin
    if (in_data_i.kind == KIND_ADD) begin
      bad_item = ({1'b0, in_data_i.row_top} >= rows_q) ||
                 ({1'b0, in_data_i.col_left} >= cols_q);
    end else begin
      bad_item = ({1'b0, in_data_i.row_bottom} >= rows_q) ||
                 ({1'b0, in_data_i.col_right} >= cols_q) ||
                 (in_data_i.row_top > in_data_i.row_bottom) ||
                 (in_data_i.col_left > in_data_i.col_right);
    end
  end

  // Select the corner and sign of the current prefix term
  always_comb begin
    case (term_q)
      2'd0: begin
        term_r = WalkW'(item_q.row_bottom) + WalkW'(1);
        term_c = WalkW'(item_q.col_right) + WalkW'(1);
        term_neg = 1'b0;
      end
      2'd1: begin
        term_r = WalkW'(item_q.row_top);
        term_c = WalkW'(item_q.col_right) + WalkW'(1);
        term_neg = 1'b1;
      end
      2'd2: begin
        term_r = WalkW'(item_q.row_bottom) + WalkW'(1);
        term_c = WalkW'(item_q.col_left);
        term_neg = 1'b1;
      end
      default: begin
        term_r = WalkW'(item_q.row_top);
        term_c = WalkW'(item_q.col_left);
        term_neg = 1'b0;
      end
    endcase
  end

  // Shared adder: node update for adds, signed accumulate for queries
  always_comb begin
    sum_a   = (item_q.kind == KIND_ADD) ? item_q.value : acc_q;
    sum_cin = (item_q.kind == KIND_QUERY) && pneg_q;
    sum_b   = ram_rdata ^ {WordW{sum_cin}};
    sum     = sum_a + sum_b + WordW'(sum_cin);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    err_d     = err_q;
    i_d       = i_q;
    j_d       = j_q;
    jstart_d  = jstart_q;
    term_d    = term_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    pneg_d    = pneg_q;
    paddr_d   = paddr_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_d     = out_q;
    ram_raddr = node_addr(i_q, j_q);
    i_next    = i_q;
    j_next    = j_q;

    // Retire the query node read issued in the previous cycle
    if (pend_q && item_q.kind == KIND_QUERY) begin
      acc_d = sum;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          item_d   = in_data_i;
          err_d    = bad_item;
          acc_d    = '0;
          term_d   = '0;
          i_d      = WalkW'(in_data_i.row_top) + WalkW'(1);
          j_d      = WalkW'(in_data_i.col_left) + WalkW'(1);
          jstart_d = WalkW'(in_data_i.col_left) + WalkW'(1);
          if (bad_item) begin
            state_d = ST_DONE;
          end else if (in_data_i.kind == KIND_ADD) begin
            state_d = ST_ADD;
          end else begin
            state_d = ST_QINIT;
          end
        end
      end
      ST_ADD: begin
        // Issue a node read and climb the column chain, then the row chain
        pend_d  = 1'b1;
        pneg_d  = 1'b0;
        paddr_d = ram_raddr;
        j_next  = j_q + lowbit(j_q);
        if (j_next > {1'b0, cols_q}) begin
          i_next = i_q + lowbit(i_q);
          j_d    = jstart_q;
          i_d    = i_next;
          if (i_next > {1'b0, rows_q}) begin
            state_d = ST_DRAIN;
          end
        end else begin
          j_d = j_next;
        end
      end
      ST_QINIT: begin
        // Load the next prefix corner, skip empty prefixes
        if (term_r == '0 || term_c == '0) begin
          term_d = term_q + 2'd1;
          if (term_q == 2'd3) begin
            state_d = ST_DRAIN;
          end
        end else begin
          i_d      = term_r;
          j_d      = term_c;
          jstart_d = term_c;
          state_d  = ST_QWALK;
        end
      end
      ST_QWALK: begin
        // Issue a node read and descend the column chain, then the row chain
        pend_d  = 1'b1;
        pneg_d  = term_neg;
        paddr_d = ram_raddr;
        j_next  = j_q - lowbit(j_q);
        if (j_next == '0) begin
          i_next = i_q - lowbit(i_q);
          j_d    = jstart_q;
          i_d    = i_next;
          if (i_next == '0) begin
            term_d = term_q + 2'd1;
            state_d = (term_q == 2'd3) ? ST_DRAIN : ST_QINIT;
          end
        end else begin
          j_d = j_next;
        end
      end
      ST_DRAIN: begin
        // Any read still pending retires this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.rect_sum  = acc_q;
          out_d.status    = err_q ? STATUS_ERR : STATUS_OK;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM write: clearing pass or node update
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_q && (item_q.kind == KIND_ADD);
      ram_waddr = paddr_q;
      ram_wdata = sum;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SizeW'(RowsRst);
      cols_q <= SizeW'(ColsRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= clamp_size(cfg_data_i, MAX_ROWS);
        CFG_COLS: cols_q <= clamp_size(cfg_data_i, MAX_COLS);
        default: ;
      endcase
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    err_q    <= err_d;
    i_q      <= i_d;
    j_q      <= j_d;
    jstart_q <= jstart_d;
    term_q   <= term_d;
    acc_q    <= acc_d;
    pneg_q   <= pneg_d;
    paddr_q  <= paddr_d;
    out_q    <= out_d;
  end

  fwt2d_ram #(
    .WIDTH(WordW),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
